FILE: hdl/stwp_pkg.sv
// ----------------------------------------------------------------------------
// stwp_pkg
// Shared types and constants for the section time window profiler.
// ----------------------------------------------------------------------------
package stwp_pkg;

    localparam int MAX_SECTIONS = 16;
    localparam int SEC_W        = 4;
    localparam int SLOT_W       = 32;
    localparam int TOTAL_W      = 40;
    localparam int CNT_W        = 7;
    localparam int WIN_W        = 7;
    localparam int NSEC_W       = 5;

    localparam logic [NSEC_W-1:0] SEC_CAP = NSEC_W'(MAX_SECTIONS);

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_NEXT  = 2'd2;
    localparam logic [1:0] ACT_QUERY = 2'd3;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_WINDOW   = 2'd1;
    localparam logic [1:0] REG_SECTIONS = 2'd2;

    typedef struct packed {
        logic              enable;
        logic [WIN_W-1:0]  window;
        logic [NSEC_W-1:0] sections;
    } prof_cfg_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [SEC_W-1:0] section;
        logic             sec_ok;
    } cmd_t;

    typedef struct packed {
        logic [SEC_W-1:0]   section;
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] average;
        logic [CNT_W-1:0]   count;
    } result_t;

endpackage

FILE: hdl/stwp_fifo.sv
// ----------------------------------------------------------------------------
// stwp_fifo
// Small register-based word queue with full/empty flags.
// ----------------------------------------------------------------------------
module stwp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/stwp_div.sv
// ----------------------------------------------------------------------------
// stwp_div
// Radix-2 restoring divider: total by frame count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module stwp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [stwp_pkg::TOTAL_W-1:0] dividend,
    input  logic [stwp_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [stwp_pkg::TOTAL_W-1:0] quotient
);
    import stwp_pkg::*;

    localparam int STEP_W = $clog2(TOTAL_W + 1);
    localparam int REM_W  = CNT_W + 1;

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [TOTAL_W-1:0]  q_reg;
    logic [TOTAL_W-1:0]  q_next;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-1:0]    rem_next;
    logic [CNT_W-1:0]    d_reg;
    logic [CNT_W-1:0]    d_next;
    logic [REM_W-1:0]    trial;

    assign done     = done_reg;
    assign quotient = q_reg;
    assign trial    = {rem_reg[REM_W-2:0], q_reg[TOTAL_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(TOTAL_W);
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= REM_W'(d_reg))
            begin
                rem_next = trial - REM_W'(d_reg);
                q_next   = {q_reg[TOTAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[TOTAL_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

endmodule

FILE: hdl/stwp_front.sv
// ----------------------------------------------------------------------------
// stwp_front
// Accepts events, drops those that have no effect, queues the rest.
// ----------------------------------------------------------------------------
module stwp_front #(
    parameter int TIME_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stwp_pkg::prof_cfg_t         cfg,
    input  logic                        busy,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  action,
    input  logic [stwp_pkg::SEC_W-1:0]  section,
    input  logic [TIME_BITS-1:0]        timestamp,
    input  logic                        cmd_pop,
    output logic                        cmd_empty,
    output stwp_pkg::cmd_t              cmd,
    output logic [TIME_BITS-1:0]        cmd_ts
);
    import stwp_pkg::*;

    localparam int CMD_W = $bits(cmd_t) + TIME_BITS;

    logic             q_full;
    logic             accept;
    logic             sec_ok;
    logic             keep;
    cmd_t             in_cmd;
    logic [CMD_W-1:0] q_out;

    assign full   = q_full || busy;
    assign accept = push && !full;
    assign sec_ok = ({1'b0, section} < cfg.sections);
    assign keep   = cfg.enable && ((action != ACT_START) || sec_ok);

    assign in_cmd.action  = action;
    assign in_cmd.section = section;
    assign in_cmd.sec_ok  = sec_ok;

    stwp_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && keep),
        .wr_data ({in_cmd, timestamp}),
        .rd_en   (cmd_pop),
        .rd_data (q_out),
        .full    (q_full),
        .empty   (cmd_empty)
    );

    assign cmd    = q_out[CMD_W-1:TIME_BITS];
    assign cmd_ts = q_out[TIME_BITS-1:0];

endmodule

FILE: hdl/stwp_back.sv
// ----------------------------------------------------------------------------
// stwp_back
// Executes queued events: slot charging, frame advance sweep, queries.
// Holds the slot memory, section totals and timing state.
// ----------------------------------------------------------------------------
module stwp_back #(
    parameter int MAX_WINDOW = 64,
    parameter int TIME_BITS  = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  stwp_pkg::prof_cfg_t    cfg,
    input  logic                   clear,
    output logic                   busy,
    input  logic                   cmd_empty,
    output logic                   cmd_pop,
    input  stwp_pkg::cmd_t         cmd,
    input  logic [TIME_BITS-1:0]   cmd_ts,
    input  logic                   res_full,
    output logic                   res_push,
    output stwp_pkg::result_t      res
);
    import stwp_pkg::*;

    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int ADDR_W = PTR_W + SEC_W;
    localparam int DEPTH  = MAX_WINDOW * MAX_SECTIONS;
    localparam int MOD_W  = ($clog2(MAX_WINDOW + 1) > WIN_W) ? $clog2(MAX_WINDOW + 1) : WIN_W;
    localparam int SUM_W  = ((TIME_BITS > SLOT_W) ? TIME_BITS : SLOT_W) + 1;
    localparam logic [WIN_W-1:0] WIN_CAP = (MAX_WINDOW > 127) ? 7'd127 : WIN_W'(MAX_WINDOW);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_CHARGE = 4'd3;
    localparam logic [3:0] S_MOD    = 4'd4;
    localparam logic [3:0] S_NF_A   = 4'd5;
    localparam logic [3:0] S_NF_B   = 4'd6;
    localparam logic [3:0] S_NF_C   = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]           state_reg;
    logic [3:0]           state_next;
    cmd_t                 cur_reg;
    cmd_t                 cur_next;
    logic [TIME_BITS-1:0] ts_reg;
    logic [TIME_BITS-1:0] ts_next;
    logic [TIME_BITS-1:0] last_time_reg;
    logic [TIME_BITS-1:0] last_time_next;
    logic                 running_reg;
    logic                 running_next;
    logic [SEC_W-1:0]     open_sec_reg;
    logic [SEC_W-1:0]     open_sec_next;
    logic [PTR_W-1:0]     ptr_reg;
    logic [PTR_W-1:0]     ptr_next;
    logic [CNT_W-1:0]     frame_cnt_reg;
    logic [CNT_W-1:0]     frame_cnt_next;
    logic [TOTAL_W-1:0]   totals_reg [MAX_SECTIONS];
    logic [TOTAL_W-1:0]   totals_next [MAX_SECTIONS];
    logic [SEC_W-1:0]     idx_reg;
    logic [SEC_W-1:0]     idx_next;
    logic [TOTAL_W-1:0]   acc_reg;
    logic [TOTAL_W-1:0]   acc_next;
    logic [MOD_W-1:0]     nxt_reg;
    logic [MOD_W-1:0]     nxt_next;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [ADDR_W-1:0]    clr_addr_next;
    result_t              res_reg;
    result_t              res_next;

    logic [SLOT_W-1:0]    slot_mem [DEPTH];
    logic [SLOT_W-1:0]    rdata_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 we;
    logic [ADDR_W-1:0]    wr_addr;
    logic [SLOT_W-1:0]    wdata;

    logic [TIME_BITS-1:0] delta;
    logic [SUM_W-1:0]     sum;
    logic [SLOT_W-1:0]    sat_sum;
    logic [PTR_W-1:0]     nxt_ptr;
    logic                 div_start;
    logic                 div_done;
    logic [TOTAL_W-1:0]   div_q;
    logic                 div_arm_reg;

    assign busy     = (state_reg == S_CLEAR);
    assign res      = res_reg;
    assign delta    = ts_reg - last_time_reg;
    assign sum      = SUM_W'(rdata_reg) + SUM_W'(delta);
    assign sat_sum  = (|sum[SUM_W-1:SLOT_W]) ? '1 : sum[SLOT_W-1:0];
    assign nxt_ptr  = nxt_reg[PTR_W-1:0];

    stwp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (res_reg.total),
        .divisor  (frame_cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        ts_next        = ts_reg;
        last_time_next = last_time_reg;
        running_next   = running_reg;
        open_sec_next  = open_sec_reg;
        ptr_next       = ptr_reg;
        frame_cnt_next = frame_cnt_reg;
        totals_next    = totals_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        nxt_next       = nxt_reg;
        clr_addr_next  = clr_addr_reg;
        res_next       = res_reg;
        rd_addr        = {ptr_reg, open_sec_reg};
        we             = 1'b0;
        wr_addr        = {ptr_reg, open_sec_reg};
        wdata          = '0;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                we      = 1'b1;
                wr_addr = clr_addr_reg;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    cur_next   = cmd;
                    ts_next    = cmd_ts;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (cur_reg.action)
                    ACT_START, ACT_STOP:
                    begin
                        if (running_reg)
                        begin
                            state_next = S_CHARGE;
                        end
                        else
                        begin
                            last_time_next = ts_reg;
                            running_next   = (cur_reg.action == ACT_START);
                            if (cur_reg.action == ACT_START)
                            begin
                                open_sec_next = cur_reg.section;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    ACT_NEXT:
                    begin
                        nxt_next   = MOD_W'(ptr_reg) + 1'b1;
                        state_next = S_MOD;
                    end
                    default:
                    begin
                        res_next.section = cur_reg.section;
                        res_next.total   = cur_reg.sec_ok ? totals_reg[cur_reg.section] : '0;
                        res_next.average = '0;
                        res_next.count   = frame_cnt_reg;
                        if (cur_reg.sec_ok && (frame_cnt_reg != '0))
                        begin
                            state_next = S_DIV;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                endcase
            end
            S_CHARGE:
            begin
                we             = 1'b1;
                wdata          = sat_sum;
                last_time_next = ts_reg;
                running_next   = (cur_reg.action == ACT_START);
                if (cur_reg.action == ACT_START)
                begin
                    open_sec_next = cur_reg.section;
                end
                state_next = S_IDLE;
            end
            S_MOD:
            begin
                if (nxt_reg >= MOD_W'(cfg.window))
                begin
                    nxt_next = nxt_reg - MOD_W'(cfg.window);
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_NF_A;
                end
            end
            S_NF_A:
            begin
                rd_addr    = {ptr_reg, idx_reg};
                state_next = S_NF_B;
            end
            S_NF_B:
            begin
                acc_next   = totals_reg[idx_reg] + TOTAL_W'(rdata_reg);
                rd_addr    = {nxt_ptr, idx_reg};
                state_next = S_NF_C;
            end
            S_NF_C:
            begin
                totals_next[idx_reg] = acc_reg - TOTAL_W'(rdata_reg);
                we      = 1'b1;
                wr_addr = {nxt_ptr, idx_reg};
                if ({1'b0, idx_reg} == cfg.sections - 1'b1)
                begin
                    ptr_next       = nxt_ptr;
                    frame_cnt_next = (frame_cnt_reg < cfg.window) ? frame_cnt_reg + 1'b1
                                                                   : cfg.window;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    rd_addr    = {ptr_reg, idx_reg + 1'b1};
                    state_next = S_NF_B;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next.average = div_q;
                    state_next       = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear)
        begin
            state_next     = S_CLEAR;
            clr_addr_next  = '0;
            ptr_next       = '0;
            frame_cnt_next = '0;
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                totals_next[i] = '0;
            end
        end
    end

    // divider is fed from res_reg.total, so start it in the cycle after the load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_arm_reg <= 1'b0;
        end
        else
        begin
            div_arm_reg <= (state_reg == S_DISP) && (state_next == S_DIV);
        end
    end

    assign div_start = div_arm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            last_time_reg <= '0;
            running_reg   <= 1'b0;
            open_sec_reg  <= '0;
            ptr_reg       <= '0;
            frame_cnt_reg <= '0;
            clr_addr_reg  <= '0;
            idx_reg       <= '0;
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                totals_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            last_time_reg <= last_time_next;
            running_reg   <= running_next;
            open_sec_reg  <= open_sec_next;
            ptr_reg       <= ptr_next;
            frame_cnt_reg <= frame_cnt_next;
            clr_addr_reg  <= clr_addr_next;
            idx_reg       <= idx_next;
            totals_reg    <= totals_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ts_reg  <= ts_next;
        acc_reg <= acc_next;
        nxt_reg <= nxt_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_mem[wr_addr] <= wdata;
        end
        rdata_reg <= slot_mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");
    a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!res_push && !cmd_pop))
        else $error("activity during clearing pass");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_cnt_reg <= CNT_W'(WIN_CAP))
        else $error("frame counter beyond window cap");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside query");
`endif

endmodule

FILE: hdl/section_time_window_profiler.sv
// ----------------------------------------------------------------------------
// section_time_window_profiler
// Per-section tick totals over a sliding window of frames.
// ----------------------------------------------------------------------------
// Usage:
//   Event words enter through push/full: action, section, timestamp. A word
//   is taken when push is high and full is low. Query results leave through
//   empty/pop: the oldest result is on the result ports while empty is low.
//   Registers are written through cfg_valid/cfg_ready (always ready) with
//   cfg_index and cfg_data, by the user only while the block is idle, which
//   the block does not enforce. Start/stop pass through dispatch and, while
//   a section is open, a charge state that adds the elapsed ticks, saturating,
//   to its slot. Next frame wraps the slot pointer by the window and sweeps
//   the sections through the one read port. A query with a valid section and
//   frames counted waits for the one-bit-per-cycle divider. Events run one
//   at a time; the event queue and the result queue each hold two words.
// Reset and enable:
//   Reset and every write of 1 to the enable register run a clearing pass
//   over all MAX_WINDOW*16 slot memory words; full stays high meanwhile.
//   A stalled receiver fills the result queue, then the event queue.
// ----------------------------------------------------------------------------
module section_time_window_profiler #(
    parameter int MAX_WINDOW = 64,
    parameter int TIME_BITS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [6:0]                   cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   action,
    input  logic [stwp_pkg::SEC_W-1:0]   section,
    input  logic [TIME_BITS-1:0]         timestamp,
    output logic                         empty,
    input  logic                         pop,
    output logic [stwp_pkg::SEC_W-1:0]   queried_section,
    output logic [stwp_pkg::TOTAL_W-1:0] total_ticks,
    output logic [stwp_pkg::TOTAL_W-1:0] average_ticks,
    output logic [stwp_pkg::CNT_W-1:0]   frames_counted
);
    import stwp_pkg::*;

    localparam logic [WIN_W-1:0] WIN_CAP = (MAX_WINDOW > 127) ? 7'd127 : WIN_W'(MAX_WINDOW);
    localparam int RES_W = $bits(result_t);

    logic              enable_reg;
    logic              enable_next;
    logic [WIN_W-1:0]  window_reg;
    logic [WIN_W-1:0]  window_next;
    logic [NSEC_W-1:0] sections_reg;
    logic [NSEC_W-1:0] sections_next;
    logic              cfg_wr;
    logic              clear;
    prof_cfg_t         cfg;

    logic                 busy;
    logic                 cmd_empty;
    logic                 cmd_pop;
    cmd_t                 cmd;
    logic [TIME_BITS-1:0] cmd_ts;
    logic                 res_full;
    logic                 res_push;
    result_t              res_in;
    logic [RES_W-1:0]     res_out;
    result_t              res_q;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign clear     = cfg_wr && (cfg_index == REG_ENABLE) && cfg_data[0];

    always_comb
    begin
        enable_next   = enable_reg;
        window_next   = window_reg;
        sections_next = sections_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                REG_ENABLE:   enable_next   = cfg_data[0];
                REG_WINDOW:   window_next   = cfg_data;
                REG_SECTIONS: sections_next = cfg_data[NSEC_W-1:0];
                default:      enable_next   = enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            window_reg   <= 7'd60;
            sections_reg <= 5'd1;
        end
        else
        begin
            enable_reg   <= enable_next;
            window_reg   <= window_next;
            sections_reg <= sections_next;
        end
    end

    assign cfg.enable   = enable_reg;
    assign cfg.window   = (window_reg == '0) ? WIN_W'(1)
                        : ((window_reg > WIN_CAP) ? WIN_CAP : window_reg);
    assign cfg.sections = (sections_reg == '0) ? NSEC_W'(1)
                        : ((sections_reg > SEC_CAP) ? SEC_CAP : sections_reg);

    stwp_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .busy      (busy),
        .push      (push),
        .full      (full),
        .action    (action),
        .section   (section),
        .timestamp (timestamp),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd       (cmd),
        .cmd_ts    (cmd_ts)
    );

    stwp_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .clear     (clear),
        .busy      (busy),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_ts    (cmd_ts),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    stwp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (res_full),
        .empty   (empty)
    );

    assign res_q           = res_out;
    assign queried_section = res_q.section;
    assign total_ticks     = res_q.total;
    assign average_ticks   = res_q.average;
    assign frames_counted  = res_q.count;

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for section_time_window_profiler. A directed table of
// events and register writes runs first. Randomized phases follow, each with
// its own window and section settings. Input arrives in bursts and the result
// consumer stalls at random. Every query report is compared field by field
// against an in-bench profile of slot ticks, window totals and frame count.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stwp_pkg::*;

    localparam int WINDOW_CAP    = 64;
    localparam int IDLE_LIMIT    = 6000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 600;
    localparam int HOLD_AT_POP   = 60;
    localparam int PHASES        = 10;

    localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF;

    localparam int EN_KEEP  = 0;
    localparam int EN_SET   = 1;
    localparam int EN_CLEAR = 2;

    localparam int DRAIN_FULL = 0;
    localparam int DRAIN_HALF = 1;
    localparam int DRAIN_SLOW = 2;

    typedef struct packed {
        logic             reg_row;
        logic [1:0]       code;
        logic [6:0]       data;
        logic [SEC_W-1:0] sec;
        logic [31:0]      ts;
        logic             pinned;
        result_t          want;
    } stim_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = REG_ENABLE;
    logic [6:0]         cfg_data  = 7'd0;
    logic               push      = 1'b0;
    logic               full;
    logic [1:0]         action    = ACT_START;
    logic [SEC_W-1:0]   section   = '0;
    logic [31:0]        timestamp = '0;
    logic               empty;
    logic               pop       = 1'b0;
    logic [SEC_W-1:0]   queried_section;
    logic [TOTAL_W-1:0] total_ticks;
    logic [TOTAL_W-1:0] average_ticks;
    logic [CNT_W-1:0]   frames_counted;

    section_time_window_profiler dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // profile state
    logic               cfg_on;
    logic [6:0]         cfg_window;
    logic [4:0]         cfg_sections;
    logic [SLOT_W-1:0]  slot_ticks [WINDOW_CAP*MAX_SECTIONS];
    logic [TOTAL_W-1:0] window_totals [MAX_SECTIONS];
    logic [31:0]        mark_ts;
    logic               clock_running;
    logic [SEC_W-1:0]   open_sec;
    int                 ring_ptr;
    int                 frames_seen;

    result_t   pending_reports [$];
    stim_row_t stim_table [$];
    result_t   head;
    int        fail_count   = 0;
    int        popped       = 0;
    int        stall_cycles = 0;
    int        hold_left    = 0;
    bit        held         = 1'b0;
    int        pop_mode     = DRAIN_FULL;
    int        mode_age     = 0;

    logic [6:0] ph_window [PHASES] =
        '{7'd2, 7'd64, 7'd5, 7'd1, 7'd0, 7'd127, 7'd3, 7'd60, 7'd16, 7'd4};
    logic [6:0] ph_sections [PHASES] =
        '{7'd4, 7'd16, 7'd16, 7'd1, 7'd0, 7'h7F, 7'd12, 7'd8, 7'd9, 7'd16};
    int ph_enable [PHASES] =
        '{EN_SET, EN_SET, EN_KEEP, EN_KEEP, EN_KEEP, EN_KEEP, EN_SET, EN_CLEAR,
          EN_SET, EN_KEEP};
    int ph_items [PHASES] = '{180, 360, 150, 100, 100, 200, 150, 40, 140, 140};

    function automatic int live_window();
        int w = cfg_window;
        if (w < 1) w = 1;
        if (w > WINDOW_CAP) w = WINDOW_CAP;
        return w;
    endfunction

    function automatic int live_sections();
        int n = cfg_sections;
        if (n < 1) n = 1;
        if (n > MAX_SECTIONS) n = MAX_SECTIONS;
        return n;
    endfunction

    function automatic void clear_profile();
        for (int i = 0; i < WINDOW_CAP*MAX_SECTIONS; i++) slot_ticks[i] = '0;
        for (int i = 0; i < MAX_SECTIONS; i++) window_totals[i] = '0;
        frames_seen = 0;
        ring_ptr    = 0;
    endfunction

    function automatic void charge_open(logic [31:0] ts);
        logic [32:0] sum;
        int          idx;
        if (clock_running)
        begin
            idx = ring_ptr*MAX_SECTIONS + int'(open_sec);
            sum = {1'b0, slot_ticks[idx]} + {1'b0, ts - mark_ts};
            slot_ticks[idx] = sum[32] ? TICK_MAX : sum[31:0];
        end
        mark_ts       = ts;
        clock_running = 1'b1;
    endfunction

    function automatic bit profile_event(logic [1:0] act, logic [SEC_W-1:0] sec,
                                         logic [31:0] ts, output result_t rep);
        int w;
        int n;
        int nxt;
        int idx;
        rep = '0;
        if (!cfg_on) return 1'b0;
        n = live_sections();
        case (act)
            ACT_START:
                if (int'(sec) < n)
                begin
                    charge_open(ts);
                    open_sec = sec;
                end
            ACT_STOP:
            begin
                charge_open(ts);
                clock_running = 1'b0;
            end
            ACT_NEXT:
            begin
                w   = live_window();
                nxt = (ring_ptr + 1) % w;
                for (int i = 0; i < n; i++)
                    window_totals[i] = window_totals[i] +
                        TOTAL_W'(slot_ticks[ring_ptr*MAX_SECTIONS + i]);
                for (int i = 0; i < n; i++)
                begin
                    idx = nxt*MAX_SECTIONS + i;
                    window_totals[i] = window_totals[i] - TOTAL_W'(slot_ticks[idx]);
                    slot_ticks[idx] = '0;
                end
                ring_ptr = nxt;
                if (frames_seen < w) frames_seen++;
                else frames_seen = w;
            end
            default:
            begin
                rep.section = sec;
                rep.count   = CNT_W'(frames_seen);
                if (int'(sec) < n)
                begin
                    rep.total = window_totals[sec];
                    if (frames_seen != 0) rep.average = rep.total / TOTAL_W'(frames_seen);
                end
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void add_event(logic [1:0] act, logic [SEC_W-1:0] sec,
                                      logic [31:0] ts);
        stim_row_t r;
        r      = '0;
        r.code = act;
        r.sec  = sec;
        r.ts   = ts;
        stim_table.insert(stim_table.size(), r);
    endfunction

    function automatic void add_query(logic [SEC_W-1:0] sec, logic [TOTAL_W-1:0] total,
                                      logic [TOTAL_W-1:0] avg, logic [CNT_W-1:0] cnt);
        stim_row_t r;
        r              = '0;
        r.code         = ACT_QUERY;
        r.sec          = sec;
        r.pinned       = 1'b1;
        r.want.section = sec;
        r.want.total   = total;
        r.want.average = avg;
        r.want.count   = cnt;
        stim_table.insert(stim_table.size(), r);
    endfunction

    function automatic void add_reg(logic [1:0] idx, logic [6:0] data);
        stim_row_t r;
        r         = '0;
        r.reg_row = 1'b1;
        r.code    = idx;
        r.data    = data;
        stim_table.insert(stim_table.size(), r);
    endfunction

    function automatic void check_field(string name, logic [TOTAL_W-1:0] want,
                                        logic [TOTAL_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_event(input logic [1:0] act, input logic [SEC_W-1:0] sec,
                              input logic [31:0] ts, input bit pinned,
                              input result_t pinned_rep);
        result_t rep;
        bit      reported;
        push      <= 1'b1;
        action    <= act;
        section   <= sec;
        timestamp <= ts;
        @(posedge clk);
        while (full) @(posedge clk);
        reported = profile_event(act, sec, ts, rep);
        if (reported)
            pending_reports.insert(pending_reports.size(), pinned ? pinned_rep : rep);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_ENABLE:
            begin
                cfg_on = data[0];
                if (data[0]) clear_profile();
            end
            REG_WINDOW:   cfg_window   = data;
            REG_SECTIONS: cfg_sections = data[4:0];
            default: ;
        endcase
    endtask

    // drain all reports, then let queued non-reporting events finish
    task automatic settle();
        push <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            popped++;
            if (pending_reports.size() == 0)
            begin
                $error("result word with no expectation: queried_section %0d",
                       queried_section);
                fail_count++;
            end
            else
            begin
                head = pending_reports.pop_front();
                check_field("queried_section", TOTAL_W'(head.section),
                            TOTAL_W'(queried_section));
                check_field("total_ticks", head.total, total_ticks);
                check_field("average_ticks", head.average, average_ticks);
                check_field("frames_counted", TOTAL_W'(head.count),
                            TOTAL_W'(frames_counted));
            end
        end
        if (!held && popped == HOLD_AT_POP)
        begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (mode_age == 0)
        begin
            pop_mode = $urandom_range(DRAIN_FULL, DRAIN_SLOW);
            mode_age = $urandom_range(16, 128);
        end
        else
            mode_age--;
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            case (pop_mode)
                DRAIN_FULL: pop <= 1'b1;
                DRAIN_HALF: pop <= 1'($urandom_range(0, 1));
                default:    pop <= ($urandom_range(0, 6) == 0);
            endcase
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        stim_row_t        row;
        bit               prev_reg;
        bit               drained_once;
        int               burst;
        int               gap;
        int               n;
        int               sel;
        logic [1:0]       act;
        logic [SEC_W-1:0] sec;
        logic [31:0]      run_ts;

        cfg_on        = 1'b0;
        cfg_window    = 7'd60;
        cfg_sections  = 5'd1;
        clear_profile();
        mark_ts       = '0;
        clock_running = 1'b0;
        open_sec      = '0;
        prev_reg      = 1'b0;
        drained_once  = 1'b0;
        run_ts        = '0;

        // disabled after reset: ignored, no report
        add_event(ACT_START, 4'd0, 32'd0);
        add_event(ACT_QUERY, 4'd0, 32'd0);
        add_reg(REG_WINDOW, 7'd4);
        add_reg(REG_SECTIONS, 7'd4);
        add_reg(REG_ENABLE, 7'd1);
        add_query(4'd0, '0, '0, '0);
        add_query(4'd15, '0, '0, '0);
        add_event(ACT_START, 4'd0, 32'd0);
        add_event(ACT_STOP, 4'd0, TICK_MAX);
        add_event(ACT_START, 4'd1, 32'h10);
        add_event(ACT_START, 4'd5, 32'h20);     // unknown section, no charge
        add_event(ACT_START, 4'd2, 32'h30);
        add_event(ACT_STOP, 4'd0, 32'h20);      // timestamp wraps
        add_event(ACT_START, 4'd0, 32'd5);
        add_event(ACT_STOP, 4'd0, 32'd4);       // slot saturates
        add_event(ACT_NEXT, 4'd0, 32'd0);
        add_query(4'd0, 40'h00_FFFF_FFFF, 40'h00_FFFF_FFFF, 7'd1);
        add_event(ACT_QUERY, 4'd2, 32'd0);
        add_query(4'd3, '0, '0, 7'd1);
        add_event(ACT_START, 4'd3, 32'd100);
        add_event(ACT_NEXT, 4'd15, TICK_MAX);
        add_event(ACT_STOP, 4'd0, 32'd300);
        add_event(ACT_NEXT, 4'd0, 32'd0);
        add_event(ACT_NEXT, 4'd0, 32'd0);
        add_event(ACT_NEXT, 4'd0, 32'd0);
        add_event(ACT_QUERY, 4'd3, 32'd0);
        add_event(ACT_QUERY, 4'd1, 32'd0);
        add_event(ACT_NEXT, 4'd0, 32'd0);
        add_event(ACT_QUERY, 4'd0, 32'd0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            row = stim_table[i];
            if (row.reg_row)
            begin
                if (!prev_reg) settle();
                write_cfg(row.code, row.data);
            end
            else
            begin
                if (prev_reg) cfg_valid <= 1'b0;
                send_event(row.code, row.sec, row.ts, row.pinned, row.want);
            end
            prev_reg = row.reg_row;
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_cfg(REG_WINDOW, ph_window[p]);
            write_cfg(REG_SECTIONS, ph_sections[p]);
            if (ph_enable[p] == EN_SET) write_cfg(REG_ENABLE, 7'd1);
            else if (ph_enable[p] == EN_CLEAR) write_cfg(REG_ENABLE, 7'd0);
            cfg_valid <= 1'b0;
            burst = 0;
            for (int k = 0; k < ph_items[p]; k++)
            begin
                if (burst == 0)
                begin
                    burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                        : $urandom_range(1, 24);
                    if ((!drained_once && k >= 60) || $urandom_range(0, 49) == 0)
                    begin
                        drained_once = 1'b1;
                        if (pending_reports.size() != 0)
                        begin
                            push <= 1'b0;
                            while (pending_reports.size() != 0) @(posedge clk);
                        end
                    end
                    else
                    begin
                        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                        if (gap > 0)
                        begin
                            push <= 1'b0;
                            repeat (gap) @(posedge clk);
                        end
                    end
                end
                burst--;
                n   = live_sections();
                sel = $urandom_range(0, 99);
                if (sel < 35) act = ACT_START;
                else if (sel < 55) act = ACT_STOP;
                else if (sel < 75) act = ACT_NEXT;
                else act = ACT_QUERY;
                if ($urandom_range(0, 7) == 0) sec = SEC_W'($urandom_range(0, 15));
                else sec = SEC_W'($urandom_range(0, n - 1));
                if ($urandom_range(0, 15) == 0) run_ts = $urandom;
                else run_ts = run_ts + $urandom_range(0, 3000);
                send_event(act, sec, run_ts, 1'b0, '0);
            end
        end

        settle();
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: section_time_window_profiler.f
hdl/stwp_pkg.sv
hdl/stwp_fifo.sv
hdl/stwp_div.sv
hdl/stwp_front.sv
hdl/stwp_back.sv
hdl/section_time_window_profiler.sv
dv/testbench.sv
